[src/assert_macros.svh]
// Assertion macros shared by the yaw PID duty controller RTL.
// No dependencies; files that check their own logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Generic form: explicit clock and active-low reset.
`define YPD_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ypd assertion failed");
// Short form for modules clocked by clk_i with reset rst_ni.
`define YPD_ASSERT(label, prop) `YPD_ASSERT_CLK(label, clk_i, rst_ni, prop)
`else
`define YPD_ASSERT_CLK(label, clk, rst_n, prop)
`define YPD_ASSERT(label, prop)
`endif
`endif

[src/ypd_pkg.sv]
// Types, widths and constants of the yaw PID duty controller.
// No dependencies; used by every module of the block.
`default_nettype none

package ypd_pkg;

  // Field and datapath widths
  localparam int IN_W        = 10;  // yaw angle fields
  localparam int DIFF_W      = 11;  // measured - target
  localparam int ERR_W       = 19;  // scale * diff
  localparam int PROD_W      = 26;  // err * gain
  localparam int P_W         = 23;  // prod / 10
  localparam int DDIFF_W     = 20;  // last_error - err
  localparam int DERIV_W     = 20;
  localparam int INTEG_W     = 32;
  localparam int DIVIDEND_W  = 34;
  localparam int DIVISOR_W   = 10;
  localparam int CNT_W       = 6;
  localparam int DUTY_W      = 7;
  localparam int TOTAL_W     = 35;  // offset + quotient
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 10;
  localparam int S_TDATA_W   = 24;
  localparam int M_TDATA_W   = 8;

  // Constants of the control law
  localparam logic signed [INTEG_W-1:0] INTEG_RESET = INTEG_W'(400);

  // P = |prod| / 10 as (|prod| * ceil(2^29 / 10)) >> 29, exact for 26-bit magnitudes
  localparam int                  P_SHIFT = 29;
  localparam logic [PROD_W-1:0]   P_RECIP = PROD_W'(53687092);

  // Bits of magnitude each division walks through
  localparam logic [CNT_W-1:0] NBITS_INTEG = CNT_W'(ERR_W);
  localparam logic [CNT_W-1:0] NBITS_DERIV = CNT_W'(DDIFF_W);
  localparam logic [CNT_W-1:0] NBITS_DUTY  = CNT_W'(DIVIDEND_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEG_DIVISOR = 3'd1,
    REG_DERIV_DIVISOR = 3'd2,
    REG_ERROR_SCALE   = 3'd3,
    REG_DUTY_OFFSET   = 3'd4,
    REG_DUTY_MIN      = 3'd5,
    REG_DUTY_MAX      = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [6:0] prop_gain;
    logic [9:0] integ_divisor;
    logic [7:0] deriv_divisor;
    logic [7:0] error_scale;
    logic [6:0] duty_offset;
    logic [6:0] duty_min;
    logic [6:0] duty_max;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    prop_gain:     7'd9,
    integ_divisor: 10'd60,
    deriv_divisor: 8'd1,
    error_scale:   8'd40,
    duty_offset:   7'd25,
    duty_min:      7'd2,
    duty_max:      7'd98
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR_MUL,
    S_PROD_MUL,
    S_P_MUL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SUM,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    OP_INTEG,
    OP_DERIV,
    OP_DUTY
  } op_e;

  typedef struct packed {
    logic load;
    logic err_mul;
    logic prod_mul;
    logic p_mul;
    logic div_start;
    logic div_commit;
    logic sum_load;
    logic emit;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
  } dp_status_t;

  // A zero divisor acts as one
  function automatic logic [DIVISOR_W-1:0] nz_div(input logic [DIVISOR_W-1:0] d);
    return (d == '0) ? DIVISOR_W'(1) : d;
  endfunction

endpackage

`default_nettype wire

[src/ypd_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on ypd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ypd_div (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    start_i,
  input  wire  logic signed [ypd_pkg::DIVIDEND_W-1:0] dividend_i,
  input  wire  logic [ypd_pkg::DIVISOR_W-1:0]    divisor_i,   // nonzero, held while busy
  input  wire  logic [ypd_pkg::CNT_W-1:0]        nbits_i,
  output logic                                   busy_o,
  output logic                                   done_o,
  output logic signed [ypd_pkg::DIVIDEND_W-1:0]  quotient_o
);
  import ypd_pkg::*;

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    neg_q, neg_d;
  logic [DIVIDEND_W-1:0]   mag_q, mag_d;
  logic [DIVISOR_W-1:0]    rem_q, rem_d;
  logic [DIVIDEND_W-1:0]   quo_q, quo_d;

  logic [CNT_W-1:0]        bit_idx;
  logic [DIVISOR_W:0]      trial;
  logic [DIVISOR_W:0]      trial_sub;
  logic                    ge;

  assign bit_idx   = cnt_q - CNT_W'(1);
  assign trial     = {rem_q, mag_q[bit_idx]};
  assign trial_sub = trial - {1'b0, divisor_i};
  assign ge        = (trial >= {1'b0, divisor_i});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = nbits_i;
      neg_d  = dividend_i[DIVIDEND_W-1];
      mag_d  = dividend_i[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend_i)
                                         : DIVIDEND_W'(dividend_i);
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], ge};
      cnt_d = bit_idx;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    mag_q <= mag_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

  `YPD_ASSERT(a_done_follows_busy, done_q |-> $past(busy_q))
  `YPD_ASSERT(a_busy_has_bits, busy_q |-> (cnt_q != '0))

endmodule

`default_nettype wire

[src/ypd_dp.sv]
// Datapath: error and product multipliers, PID state, sum and duty clamp.
// Depends on ypd_pkg and ypd_div.
`default_nettype none

module ypd_dp (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire  ypd_pkg::cmd_t               cmd_i,
  input  wire  ypd_pkg::cfg_t               cfg_i,
  input  wire  logic [ypd_pkg::IN_W-1:0]    measured_yaw_i,
  input  wire  logic [ypd_pkg::IN_W-1:0]    target_yaw_i,
  output ypd_pkg::dp_status_t               status_o,
  output logic [ypd_pkg::DUTY_W-1:0]        duty_o
);
  import ypd_pkg::*;

  logic signed [DIFF_W-1:0]     diff_q;
  logic signed [ERR_W-1:0]      err_q;
  logic signed [ERR_W-1:0]      last_err_q;
  logic signed [PROD_W-1:0]     prod_q;
  logic signed [DDIFF_W-1:0]    ddiff_q;
  logic [P_W-1:0]               p_mag_q;
  logic signed [INTEG_W-1:0]    integ_q;
  logic signed [DERIV_W-1:0]    deriv_q;
  logic signed [DIVIDEND_W-1:0] sum_q;

  logic signed [ERR_W:0]          err_full;
  logic signed [PROD_W:0]         prod_full;
  logic [PROD_W-1:0]              prod_mag;
  logic [2*PROD_W-1:0]            p_recip;
  logic signed [P_W-1:0]          p_val;
  logic signed [DIVIDEND_W-1:0]   dividend;
  logic [DIVISOR_W-1:0]           divisor;
  logic [CNT_W-1:0]               nbits;
  logic signed [DIVIDEND_W-1:0]   quot;
  logic                           div_busy, div_done;

  logic [P_W-1:0]                 abs_p;
  logic [ERR_W-1:0]               abs_err;
  logic [11:0]                    integ_lim;   // 10 * scale
  logic [8:0]                     deriv_band;  // 2 * scale
  logic                           integ_ok, deriv_ok;
  logic signed [INTEG_W:0]        integ_sum;
  logic signed [INTEG_W-1:0]      integ_sat;
  logic signed [TOTAL_W-1:0]      total;
  logic signed [TOTAL_W-1:0]      max_s, min_s;

  assign err_full  = $signed({{(ERR_W-8){1'b0}}, cfg_i.error_scale})
                   * $signed({{(ERR_W+1-DIFF_W){diff_q[DIFF_W-1]}}, diff_q});
  assign prod_full = $signed({{(PROD_W+1-ERR_W){err_q[ERR_W-1]}}, err_q})
                   * $signed({{(PROD_W+1-DUTY_W){1'b0}}, cfg_i.prop_gain});

  // P by reciprocal of ten on the magnitude, sign put back afterwards
  assign prod_mag = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
  assign p_recip  = {{PROD_W{1'b0}}, prod_mag} * {{PROD_W{1'b0}}, P_RECIP};
  assign p_val    = prod_q[PROD_W-1] ? -$signed(p_mag_q) : $signed(p_mag_q);

  always_comb begin
    dividend = sum_q;
    divisor  = nz_div({2'b0, cfg_i.error_scale});
    nbits    = NBITS_DUTY;
    case (cmd_i.op)
      OP_INTEG: begin
        dividend = {{(DIVIDEND_W-ERR_W){err_q[ERR_W-1]}}, err_q};
        divisor  = nz_div(cfg_i.integ_divisor);
        nbits    = NBITS_INTEG;
      end
      OP_DERIV: begin
        dividend = {{(DIVIDEND_W-DDIFF_W){ddiff_q[DDIFF_W-1]}}, ddiff_q};
        divisor  = nz_div({2'b0, cfg_i.deriv_divisor});
        nbits    = NBITS_DERIV;
      end
      default: ;
    endcase
  end

  ypd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .nbits_i    (nbits),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  assign status_o.div_busy = div_busy;
  assign status_o.div_done = div_done;

  // Integration and derivative gates
  assign abs_p      = p_mag_q;
  assign abs_err    = err_q[ERR_W-1] ? ERR_W'(-err_q) : ERR_W'(err_q);
  assign integ_lim  = {1'b0, cfg_i.error_scale, 3'b0} + {3'b0, cfg_i.error_scale, 1'b0};
  assign deriv_band = {cfg_i.error_scale, 1'b0};
  assign integ_ok   = abs_p < {{(P_W-12){1'b0}}, integ_lim};
  assign deriv_ok   = abs_err > {{(ERR_W-9){1'b0}}, deriv_band};

  // Integral with saturation at the 32-bit limits
  assign integ_sum = {integ_q[INTEG_W-1], integ_q}
                   + {{(INTEG_W+1-ERR_W){quot[ERR_W-1]}}, quot[ERR_W-1:0]};
  always_comb begin
    integ_sat = integ_sum[INTEG_W-1:0];
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integ_sat = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                     : {1'b0, {(INTEG_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
      integ_q    <= INTEG_RESET;
      deriv_q    <= '0;
    end else begin
      if (cmd_i.prod_mul) begin
        last_err_q <= err_q;
      end
      if (cmd_i.div_commit && cmd_i.op == OP_INTEG && integ_ok) begin
        integ_q <= integ_sat;
      end
      if (cmd_i.div_commit && cmd_i.op == OP_DERIV && deriv_ok) begin
        deriv_q <= quot[DERIV_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      diff_q <= {measured_yaw_i[IN_W-1], measured_yaw_i}
              - {target_yaw_i[IN_W-1], target_yaw_i};
    end
    if (cmd_i.err_mul) begin
      err_q <= err_full[ERR_W-1:0];
    end
    if (cmd_i.prod_mul) begin
      prod_q  <= prod_full[PROD_W-1:0];
      ddiff_q <= {last_err_q[ERR_W-1], last_err_q} - {err_q[ERR_W-1], err_q};
    end
    if (cmd_i.p_mul) begin
      p_mag_q <= p_recip[P_SHIFT +: P_W];
    end
    if (cmd_i.sum_load) begin
      sum_q <= {{(DIVIDEND_W-P_W){p_val[P_W-1]}}, p_val}
             + {{(DIVIDEND_W-INTEG_W){integ_q[INTEG_W-1]}}, integ_q}
             + {{(DIVIDEND_W-DERIV_W){deriv_q[DERIV_W-1]}}, deriv_q};
    end
  end

  // Duty: offset plus final quotient, max tested before min
  assign total = $signed({{(TOTAL_W-DUTY_W){1'b0}}, cfg_i.duty_offset})
               + {quot[DIVIDEND_W-1], quot};
  assign max_s = $signed({{(TOTAL_W-DUTY_W){1'b0}}, cfg_i.duty_max});
  assign min_s = $signed({{(TOTAL_W-DUTY_W){1'b0}}, cfg_i.duty_min});

  always_comb begin
    if (total > max_s) begin
      duty_o = cfg_i.duty_max;
    end else if (total < min_s) begin
      duty_o = cfg_i.duty_min;
    end else begin
      duty_o = total[DUTY_W-1:0];
    end
  end

endmodule

`default_nettype wire

[src/ypd_ctrl.sv]
// Sequencer of the PID tick: multiplies, three divisions, sum and output.
// Depends on ypd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ypd_ctrl (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire                        out_free_i,
  input  wire  ypd_pkg::dp_status_t  dp_status_i,
  output ypd_pkg::cmd_t              cmd_o
);
  import ypd_pkg::*;

  state_e state_q, state_d;
  op_e    op_q, op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_INTEG;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    cmd_o      = '0;
    cmd_o.op   = op_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_ERR_MUL;
        end
      end
      S_ERR_MUL: begin
        cmd_o.err_mul = 1'b1;
        state_d       = S_PROD_MUL;
      end
      S_PROD_MUL: begin
        cmd_o.prod_mul = 1'b1;
        state_d        = S_P_MUL;
      end
      S_P_MUL: begin
        cmd_o.p_mul = 1'b1;
        op_d        = OP_INTEG;
        state_d     = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (dp_status_i.div_done) begin
          cmd_o.div_commit = 1'b1;
          unique case (op_q)
            OP_INTEG: begin
              op_d    = OP_DERIV;
              state_d = S_DIV_GO;
            end
            OP_DERIV: state_d = S_SUM;
            OP_DUTY:  state_d = S_OUT;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_SUM: begin
        cmd_o.sum_load = 1'b1;
        op_d           = OP_DUTY;
        state_d        = S_DIV_GO;
      end
      S_OUT: begin
        if (out_free_i) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  `YPD_ASSERT(a_start_div_idle, cmd_o.div_start |-> !dp_status_i.div_busy)
  `YPD_ASSERT(a_done_while_waiting, dp_status_i.div_done |-> (state_q == S_DIV_WAIT))
  `YPD_ASSERT(a_load_then_mul, cmd_o.load |=> (state_q == S_ERR_MUL))

endmodule

`default_nettype wire

[src/yaw_pid_duty_controller_top.sv]
// Top level of the yaw PID duty controller: config registers, output register.
// Depends on ypd_pkg, ypd_ctrl and ypd_dp.
`default_nettype none

// Yaw PID duty controller
// -----------------------
// One word on the slave stream is one control tick: measured and target yaw in
// degrees. The block forms the scaled error, runs P, conditionally integrated I
// and held D terms, and returns one word on the master stream: the duty percent
// clamped to [duty_min, duty_max].
// Each tick steps through the error multiply, the product multiply and P by
// ten as one reciprocal multiply; the three divisions (error by integ_divisor
// over 19 bits, error step by deriv_divisor over 20, then, after the sum, sum
// by error_scale over 34) share one divider that retires one quotient bit per
// cycle; the result register is loaded when the master side is free.
// A new word is taken only once the last tick has reached the output register,
// and is taken while that result still waits in the output register.
// Stall: if the receiver holds m_axis_tready low, the result stays in the
// output register and the next tick stalls at its final step until it drains.
// Reset: rst_ni clears the state machine, the valid flag, last error and
// derivative, loads the integral with 400 and the registers with their
// defaults. Config writes are registered; write only while idle.
module yaw_pid_duty_controller_top (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // slave stream
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // [9:0] measured_yaw, [19:10] target_yaw, [23:20] zero
  input  wire  logic [ypd_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // master stream
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // [6:0] duty, [7] zero
  output logic [ypd_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  // configuration write port
  input  wire                                cfg_we_i,
  input  wire  logic [ypd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire  logic [ypd_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import ypd_pkg::*;

  cfg_t                cfg_q;
  cmd_t                cmd;
  dp_status_t          dp_status;
  logic                out_valid_q;
  logic [DUTY_W-1:0]   out_duty_q;
  logic [DUTY_W-1:0]   dp_duty;
  logic                out_free;

  // Config registers; indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_PROP_GAIN:     cfg_q.prop_gain     <= cfg_wdata_i[6:0];
        REG_INTEG_DIVISOR: cfg_q.integ_divisor <= cfg_wdata_i[9:0];
        REG_DERIV_DIVISOR: cfg_q.deriv_divisor <= cfg_wdata_i[7:0];
        REG_ERROR_SCALE:   cfg_q.error_scale   <= cfg_wdata_i[7:0];
        REG_DUTY_OFFSET:   cfg_q.duty_offset   <= cfg_wdata_i[6:0];
        REG_DUTY_MIN:      cfg_q.duty_min      <= cfg_wdata_i[6:0];
        REG_DUTY_MAX:      cfg_q.duty_max      <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // Result register can take a word if empty or draining this cycle
  assign out_free = !out_valid_q || m_axis_tready;

  ypd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_free_i  (out_free),
    .dp_status_i (dp_status),
    .cmd_o       (cmd)
  );

  ypd_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_i          (cfg_q),
    .measured_yaw_i (s_axis_tdata[IN_W-1:0]),
    .target_yaw_i   (s_axis_tdata[2*IN_W-1:IN_W]),
    .status_o       (dp_status),
    .duty_o         (dp_duty)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.emit) begin
      out_duty_q <= dp_duty;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W-DUTY_W){1'b0}}, out_duty_q};

endmodule

`default_nettype wire

[test/yaw_pid_duty_controller_top_tb.sv]
// Self-checking testbench of the yaw PID duty controller top level.
// Needs ypd_pkg and yaw_pid_duty_controller_top; drives both streams and the
// register write port, and predicts every duty word from its own copy of the law.
`timescale 1ns / 100ps

module yaw_pid_duty_controller_top_tb;
  import ypd_pkg::*;

  // Spare register index: writes to it must be dropped by the block
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  // Predictor constants
  localparam longint I32_MAX     = 64'sd2147483647;
  localparam longint I32_MIN     = -64'sd2147483648;
  localparam longint INTEG_START = 64'sd400;
  localparam longint P_SCALE     = 64'sd10;  // gain is in tenths
  localparam longint INTEG_BAND  = 64'sd10;  // integrate while |P| < 10 * scale
  localparam longint DERIV_BAND  = 64'sd2;   // refresh D while |e| > 2 * scale

  // Run control
  localparam int LONG_HOLD    = 500;   // receiver hold-off, about six ticks of work
  localparam int DRAIN_CYCLES = 120;   // longer than the latency of one tick
  localparam int STALL_LIMIT  = 3000;  // cycles with no word moving on either side
  localparam int NUM_DIRECTED = 21;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // [9:0] measured_yaw, [19:10] target_yaw, [23:20] zero
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [6:0] duty, [7] zero
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;

  yaw_pid_duty_controller_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Directed ticks: duty of -1 means "take the predicted value"; the typed
  // values are the ones that follow straight from the reset defaults.
  typedef struct packed {
    logic signed [9:0] meas;
    logic signed [9:0] targ;
    logic signed [7:0] duty;
  } tick_row_t;

  tick_row_t directed_ticks [0:NUM_DIRECTED-1] = '{
    '{10'sd0,    10'sd0,    8'sd35},  // reset state: 25 + 400/40
    '{10'sd0,    10'sd0,    8'sd35},
    '{-10'sd512, 10'sd511,  8'sd98},  // full negative error, D kicks to the top
    '{-10'sd512, 10'sd511,  8'sd2},   // same error again, D drops to zero
    '{10'sd511,  -10'sd512, 8'sd2},   // full swing the other way
    '{10'sd0,    10'sd0,    -8'sd1},  // zero error: D held
    '{10'sd2,    10'sd0,    -8'sd1},  // |e| right at 2*scale: D still held
    '{10'sd3,    10'sd0,    -8'sd1},  // just past it: D refreshed
    '{10'sd0,    -10'sd2,   -8'sd1},
    '{10'sd11,   10'sd0,    -8'sd1},  // |P| just under the integration band
    '{10'sd12,   10'sd0,    -8'sd1},  // just over it: integral frozen
    '{-10'sd11,  10'sd0,    -8'sd1},
    '{-10'sd12,  10'sd0,    -8'sd1},
    '{-10'sd1,   10'sd0,    -8'sd1},  // small negative e, integ step truncates to 0
    '{10'sd0,    -10'sd1,   -8'sd1},
    '{10'sd511,  10'sd511,  -8'sd1},
    '{-10'sd512, -10'sd512, -8'sd1},
    '{10'sd360,  -10'sd360, -8'sd1},
    '{-10'sd360, 10'sd360,  -8'sd1},
    '{10'sd1,    10'sd0,    -8'sd1},
    '{10'sd0,    10'sd0,    -8'sd1}
  };

  // Predictor state and register copy
  cfg_t   cfg_mirror = '{
    prop_gain: 7'd9, integ_divisor: 10'd60, deriv_divisor: 8'd1, error_scale: 8'd40,
    duty_offset: 7'd25, duty_min: 7'd2, duty_max: 7'd98
  };
  longint last_err   = 0;
  longint integ_acc  = INTEG_START;
  longint deriv_hold = 0;

  logic [6:0] duty_expected [$];  // predicted duty per word in flight

  // Test bookkeeping
  int         fail_count = 0;
  int         ticks_sent = 0;
  int         words_checked = 0;
  int         settings_loaded = 1;  // reset defaults count as the first
  int         stall_cycles = 0;
  int         tick_typed = -1;      // typed duty of the word on the slave bus
  logic       idle_en = 1'b1;
  logic       hold_req = 1'b0;
  logic signed [9:0] aim_yaw = '0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint div_or_one(input longint d);
    return (d == 0) ? 64'sd1 : d;
  endfunction

  // One control tick of the law; advances the predictor state.
  function automatic logic [6:0] predict_duty(input logic signed [9:0] meas,
                                              input logic signed [9:0] targ);
    longint scale, gain, offs, dmin, dmax, prev, err, p, acc, duty;
    scale = longint'(cfg_mirror.error_scale);
    gain  = longint'(cfg_mirror.prop_gain);
    offs  = longint'(cfg_mirror.duty_offset);
    dmin  = longint'(cfg_mirror.duty_min);
    dmax  = longint'(cfg_mirror.duty_max);
    prev  = last_err;
    err   = scale * (longint'(meas) - longint'(targ));
    p     = (err * gain) / P_SCALE;
    last_err = err;
    if ((p < 0 ? -p : p) < INTEG_BAND * scale) begin
      acc = integ_acc + err / div_or_one(longint'(cfg_mirror.integ_divisor));
      if (acc > I32_MAX) acc = I32_MAX;
      else if (acc < I32_MIN) acc = I32_MIN;
      integ_acc = acc;
    end
    if ((err < 0 ? -err : err) > DERIV_BAND * scale)
      deriv_hold = (prev - err) / div_or_one(longint'(cfg_mirror.deriv_divisor));
    duty = offs + (p + integ_acc + deriv_hold) / div_or_one(scale);
    if (duty > dmax) duty = dmax;
    else if (duty < dmin) duty = dmin;
    return duty[6:0];
  endfunction

  // Scoreboard: predict on every accepted tick, check every accepted duty word.
  always @(posedge clk_i) begin : scoreboard
    logic [6:0] want;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      want = predict_duty(s_axis_tdata[9:0], s_axis_tdata[19:10]);
      if (tick_typed >= 0) want = tick_typed[6:0];
      duty_expected.push_back(want);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (duty_expected.size() == 0) begin
        $error("duty word %0d with no tick waiting", m_axis_tdata[6:0]);
        fail_count++;
      end else begin
        want = duty_expected.pop_front();
        words_checked++;
        if (m_axis_tdata[6:0] !== want) begin
          $error("duty: expected %0d, got %0d", want, m_axis_tdata[6:0]);
          fail_count++;
        end
        if (m_axis_tdata[7] !== 1'b0) begin
          $error("pad: expected 0, got %b", m_axis_tdata[7]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: a long stretch with no word moving either way ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles = 0;
    else if (++stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random back-pressure bursts, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(15, 1)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Offer one tick, maybe after a random gap, and return once it is taken.
  task automatic send_tick(input logic signed [9:0] meas, input logic signed [9:0] targ,
                           input int typed);
    int gap;
    gap = (idle_en && $urandom_range(3) == 0) ? $urandom_range(15, 1) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, targ, meas};
    tick_typed     = typed;
    ticks_sent++;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop valid and wait until every predicted word has come back.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (duty_expected.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [9:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      REG_PROP_GAIN:     cfg_mirror.prop_gain     = value[6:0];
      REG_INTEG_DIVISOR: cfg_mirror.integ_divisor = value[9:0];
      REG_DERIV_DIVISOR: cfg_mirror.deriv_divisor = value[7:0];
      REG_ERROR_SCALE:   cfg_mirror.error_scale   = value[7:0];
      REG_DUTY_OFFSET:   cfg_mirror.duty_offset   = value[6:0];
      REG_DUTY_MIN:      cfg_mirror.duty_min      = value[6:0];
      REG_DUTY_MAX:      cfg_mirror.duty_max      = value[6:0];
      default: ;  // spare index: ignored
    endcase
  endtask

  task automatic cfg_close();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_config(input logic [9:0] gain, idiv, ddiv, scale, offs, dmin, dmax);
    settle();
    write_reg(REG_PROP_GAIN, gain);
    write_reg(REG_INTEG_DIVISOR, idiv);
    write_reg(REG_DERIV_DIVISOR, ddiv);
    write_reg(REG_ERROR_SCALE, scale);
    write_reg(REG_DUTY_OFFSET, offs);
    write_reg(REG_DUTY_MIN, dmin);
    write_reg(REG_DUTY_MAX, dmax);
    cfg_close();
    settings_loaded++;
  endtask

  // Mostly a plausible yaw loop (measured hovering around a target that jumps
  // now and then), with some fully random pairs mixed in.
  task automatic run_ticks(input int n);
    logic signed [9:0] meas, targ;
    int noise;
    repeat (n) begin
      if ($urandom_range(7) == 0) aim_yaw = 10'($urandom);
      if ($urandom_range(9) < 7) begin
        noise = int'($urandom_range(28)) - 14;
        meas  = aim_yaw + 10'(noise);
        targ  = aim_yaw;
      end else begin
        meas = 10'($urandom);
        targ = 10'($urandom);
      end
      send_tick(meas, targ, -1);
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed ticks under the reset defaults
    for (int i = 0; i < NUM_DIRECTED; i++)
      send_tick(directed_ticks[i].meas, directed_ticks[i].targ, int'(directed_ticks[i].duty));

    // Top of the gain, divisor and scale registers; the 7-bit gain gets all ten data bits set
    load_config(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'd100, 10'd0, 10'd100);
    run_ticks(50);

    // Zero divisors, zero scale (error always zero, integral frozen)
    load_config(10'd20, 10'd0, 10'd0, 10'd0, 10'd50, 10'd5, 10'd95);
    run_ticks(30);
    load_config(10'd15, 10'd0, 10'd0, 10'd1, 10'd50, 10'd0, 10'd100);
    run_ticks(40);

    // Crossed limits (min above max); the spare index must not disturb anything
    load_config(10'd9, 10'd60, 10'd1, 10'd40, 10'd50, 10'd80, 10'd20);
    write_reg(REG_SPARE, 10'($urandom));
    cfg_close();
    run_ticks(40);

    // Back-pressure: long receiver hold-off while ticks keep coming, then a
    // sender pause until every duty word has drained
    load_config(10'd9, 10'd60, 10'd1, 10'd40, 10'd25, 10'd2, 10'd98);
    run_ticks(20);
    hold_req = 1'b1;
    run_ticks(20);
    settle();
    run_ticks(20);

    // Random settings inside the documented ranges
    repeat (3) begin
      load_config(10'($urandom_range(100)), 10'($urandom_range(1023, 1)),
                  10'($urandom_range(255, 1)), 10'($urandom_range(255, 1)),
                  10'($urandom_range(100)), 10'($urandom_range(30)),
                  10'($urandom_range(100, 70)));
      run_ticks(40);
    end

    // Any 10-bit data at all
    load_config(10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
                10'($urandom), 10'($urandom), 10'($urandom));
    run_ticks(30);

    // Last part: no idling on either side
    idle_en = 1'b0;
    load_config(10'd12, 10'd30, 10'd2, 10'd40, 10'd30, 10'd0, 10'd100);
    run_ticks(40);

    // Integrator push: P off, largest error every tick, the integral climbs in
    // steps of a quarter million with the duty pinned at the open top
    load_config(10'd0, 10'd1, 10'd1, 10'd255, 10'd0, 10'd0, 10'h7F);
    repeat (20) send_tick(10'sd511, -10'sd512, -1);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d ticks over %0d register settings, %0d duty words checked.",
             ticks_sent, settings_loaded, words_checked);
    $display("Covered field and register extremes, zero divisors, crossed limits, "
             , "long back-pressure and large integral steps.");
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/ypd_pkg.sv
src/ypd_div.sv
src/ypd_dp.sv
src/ypd_ctrl.sv
src/yaw_pid_duty_controller_top.sv
test/yaw_pid_duty_controller_top_tb.sv
